// ----- hw/rtl/xcfr_pkg.sv -----
// Shared constants and types for the XOR-checked frame receiver.
// No dependencies; imported by every module of the block.
package xcfr_pkg;

  localparam logic [7:0] FRAME_HEADER = 8'h5A;
  localparam logic [7:0] FRAME_TAIL   = 8'h5B;
  localparam int unsigned FRAME_LEN   = 8;
  // Bytes held before the last one; the last byte is checked on arrival.
  localparam int unsigned STORE_DEPTH = FRAME_LEN - 1;
  localparam int unsigned POS_W       = $clog2(FRAME_LEN);
  localparam int unsigned CSUM_IDX    = 6;

  typedef logic [7:0] byte_t;

  typedef struct packed {
    logic [7:0]  command;
    logic [15:0] data_first;
    logic [15:0] data_second;
    logic        checksum_ok;
  } frame_result_t;

endpackage

// ----- hw/rtl/xcfr_capture.sv -----
// Frame capture: header hunt, byte position counter, frame store and checksum.
// Depends on xcfr_pkg.
module xcfr_capture (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   byte_accept,
  input  xcfr_pkg::byte_t        rx_byte,
  output logic                   frame_done,
  output xcfr_pkg::frame_result_t frame_result
);
  import xcfr_pkg::*;

  logic                   capturing_r, capturing_nxt;
  logic [POS_W-1:0]       pos_r, pos_nxt;
  byte_t                  store_r [STORE_DEPTH];
  byte_t                  csum;

  localparam logic [POS_W-1:0] LAST_POS = POS_W'(FRAME_LEN - 1);

  always_comb begin
    capturing_nxt = capturing_r;
    pos_nxt       = pos_r;
    frame_done    = 1'b0;
    if (byte_accept) begin
      if (!capturing_r) begin
        if (rx_byte == FRAME_HEADER) begin
          capturing_nxt = 1'b1;
          pos_nxt       = POS_W'(1);
        end
      end else if (pos_r == LAST_POS) begin
        // last byte closes the frame whatever its value
        capturing_nxt = 1'b0;
        pos_nxt       = '0;
        frame_done    = (rx_byte == FRAME_TAIL);
      end else begin
        pos_nxt = pos_r + POS_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capturing_r <= 1'b0;
      pos_r       <= '0;
    end else begin
      capturing_r <= capturing_nxt;
      pos_r       <= pos_nxt;
    end
  end

  // Header goes to entry 0 when idle; later bytes to their position.
  always_ff @(posedge clk) begin
    if (byte_accept) begin
      if (!capturing_r) begin
        if (rx_byte == FRAME_HEADER) begin
          store_r[0] <= rx_byte;
        end
      end else if (pos_r != LAST_POS) begin
        store_r[pos_r] <= rx_byte;
      end
    end
  end

  always_comb begin
    csum = rx_byte;
    for (int i = 0; i < STORE_DEPTH; i++) begin
      if (i != CSUM_IDX) begin
        csum = csum ^ store_r[i];
      end
    end
  end

  assign frame_result.command     = store_r[1];
  assign frame_result.data_first  = {store_r[2], store_r[3]};
  assign frame_result.data_second = {store_r[4], store_r[5]};
  assign frame_result.checksum_ok = (csum == store_r[CSUM_IDX]);

endmodule

// ----- hw/rtl/xcfr_out_reg.sv -----
// Result register with valid/ready handshake towards the consumer.
// Depends on xcfr_pkg.
module xcfr_out_reg (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    load,
  input  xcfr_pkg::frame_result_t load_data,
  output logic                    can_load,
  output logic                    out_valid,
  input  logic                    out_ready,
  output xcfr_pkg::frame_result_t out_data
);
  import xcfr_pkg::*;

  logic          valid_r, valid_nxt;
  frame_result_t data_r;

  // Free when empty or when the held request leaves this cycle.
  assign can_load = !valid_r || out_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (out_ready) begin
      valid_nxt = 1'b0;
    end
    if (load) begin
      valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= load_data;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

// ----- hw/rtl/xor_checked_frame_receiver.sv -----
// Top level of the XOR-checked frame receiver.
// Depends on xcfr_pkg, xcfr_capture and xcfr_out_reg.
//
//   Channel  Direction  Handshake                 Payload
//   in_      input      in_valid / in_ready       in_rx_byte[7:0]
//   out_     output     out_valid / out_ready     out_command[7:0], out_data_first[15:0],
//                                                 out_data_second[15:0], out_checksum_ok
//
// One byte request is taken every cycle while the result register is empty or
// being drained; the result of a frame is registered in the cycle after its tail byte is taken.
// Throughput is one byte per cycle while the single result register stage can load.
// Reset (rst_n low, synchronous) returns the receiver to header hunt and
// empties the result register; the frame store is not cleared.
// A stalled result holds in_ready low, so no byte is lost while out_ready is low.
module xor_checked_frame_receiver (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_command,
  output logic [15:0] out_data_first,
  output logic [15:0] out_data_second,
  output logic        out_checksum_ok
);
  import xcfr_pkg::*;

  logic          byte_accept;
  logic          frame_done;
  logic          can_load;
  frame_result_t frame_result;
  frame_result_t out_data;

  // Accept a byte only when a result it may close has somewhere to go.
  assign in_ready    = can_load;
  assign byte_accept = in_valid && in_ready;

  xcfr_capture u_capture (
    .clk          (clk),
    .rst_n        (rst_n),
    .byte_accept  (byte_accept),
    .rx_byte      (in_rx_byte),
    .frame_done   (frame_done),
    .frame_result (frame_result)
  );

  // Hold a finished frame here until the consumer takes it.
  xcfr_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (frame_done),
    .load_data (frame_result),
    .can_load  (can_load),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  assign out_command     = out_data.command;
  assign out_data_first  = out_data.data_first;
  assign out_data_second = out_data.data_second;
  assign out_checksum_ok = out_data.checksum_ok;

endmodule
